FILE: rtl/fltbl_pkg.sv
// ============================================================================
// fltbl_pkg -- fuel level calibration table definitions
// Breakpoint table, field widths and the per-item flag bundle shared by the
// calibration pipeline.
// ============================================================================
package fltbl_pkg;

    localparam int CAL_POINTS = 21;
    localparam int NUM_SEG    = CAL_POINTS - 1;
    localparam int SEG_W      = $clog2(CAL_POINTS);

    localparam int RAW_W  = 16;   // sensor reading
    localparam int X_W    = 12;   // reading once known to be inside the table
    localparam int LVL_W  = 12;   // calibrated level
    localparam int DX_W   = 8;    // offset into a segment (widest segment is 237)
    localparam int DLVL_W = 8;    // level rise across one segment
    localparam int NUM_W  = DX_W + DLVL_W;

    // floor(n / d) == (n * ceil(2^K / d)) >> K holds for n < 2^NUM_W, d < 2^DX_W
    localparam int RECIP_SHIFT = NUM_W + DX_W;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int Q_W         = DLVL_W;

    localparam int RAW_LIMIT  = 4096;
    localparam int FULL_LEVEL = 3900;

    localparam logic [X_W-1:0] CAL_RAW [CAL_POINTS] = '{
        12'd1,    12'd107,  12'd344,  12'd572,  12'd800,  12'd988,  12'd1193,
        12'd1400, 12'd1606, 12'd1803, 12'd2006, 12'd2206, 12'd2407, 12'd2608,
        12'd2804, 12'd3005, 12'd3202, 12'd3423, 12'd3600, 12'd3812, 12'd3863
    };

    localparam logic [LVL_W-1:0] CAL_LVL [CAL_POINTS] = '{
        12'd0,    12'd200,  12'd400,  12'd600,  12'd800,  12'd1000, 12'd1200,
        12'd1400, 12'd1600, 12'd1800, 12'd2000, 12'd2200, 12'd2400, 12'd2600,
        12'd2800, 12'd3000, 12'd3200, 12'd3400, 12'd3600, 12'd3800, 12'd3850
    };

    // Special cases that override the interpolated level
    typedef struct packed {
        logic oor;    // reading at or above the raw limit
        logic full;   // reading past the last breakpoint
        logic zero;   // reading of zero: extrapolation goes negative
    } flags_t;

endpackage

FILE: rtl/fuel_level_calibration_table.sv
// ============================================================================
// fuel_level_calibration_table -- raw fuel sensor count to calibrated level
// Five-stage pipeline doing piecewise linear interpolation over a fixed
// 21-point breakpoint table.
// ============================================================================
// The block takes one raw sensor count per cycle while in_stall is low and
// returns one calibrated level per item, in order. Each item passes
// through the five register stages in turn and its result is presented
// from the last of them, where out_valid marks it. Readings
// of 4096 or more return level 0 with out_of_range set; readings past the
// last breakpoint return the full-tank level 3900; a reading of zero
// returns 0. Otherwise the level is interpolated between the two enclosing
// breakpoints and truncated toward zero; the division by the segment width
// is an exact multiply by a per-segment reciprocal, so there is no divider
// and nothing iterates. Stages: (1) compare the reading against all
// breakpoints, (2) pick the segment and form the offset into it, (3)
// multiply by the segment's level rise, (4) multiply by the reciprocal of
// the segment width, (5) add the segment base level and apply the special
// cases. Each stage holds its own valid bit, so a stall on the output only
// holds the stages that are full and bubbles are squeezed out.
// ============================================================================
module fuel_level_calibration_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [fltbl_pkg::RAW_W-1:0] sensor_raw,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [fltbl_pkg::LVL_W-1:0] fuel_level,
    output logic                       out_of_range
);
    import fltbl_pkg::*;

    // Per-segment constant tables, worked out at elaboration
    logic [DLVL_W-1:0]  dlvl_tab  [NUM_SEG];
    logic [RECIP_W-1:0] recip_tab [NUM_SEG];

    for (genvar g = 0; g < NUM_SEG; g++) begin : g_seg
        localparam int SegDen   = int'(CAL_RAW[g+1]) - int'(CAL_RAW[g]);
        localparam int SegRise  = int'(CAL_LVL[g+1]) - int'(CAL_LVL[g]);
        localparam int SegRecip = ((1 << RECIP_SHIFT) + SegDen - 1) / SegDen;
        assign dlvl_tab[g]  = DLVL_W'(SegRise);
        assign recip_tab[g] = RECIP_W'(SegRecip);
    end

    // Stage valid bits and advance enables: a stage loads when it is empty
    // or the stage after it loads too.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || !out_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ---------------- Stage 1: breakpoint compares ----------------
    // Bit k of the thermometer is set when the reading lies above breakpoint
    // k; bit 0 is always set so readings at or below breakpoint 1 use the
    // first segment.
    logic [NUM_SEG-1:0] s1_thermo_next, s1_thermo_reg;
    logic [X_W-1:0]     s1_x_reg;
    flags_t             s1_flags_next, s1_flags_reg;

    always_comb
    begin
        s1_thermo_next[0] = 1'b1;
        for (int k = 1; k < NUM_SEG; k++)
        begin
            s1_thermo_next[k] = sensor_raw > RAW_W'(CAL_RAW[k]);
        end
        s1_flags_next.oor  = sensor_raw >= RAW_W'(RAW_LIMIT);
        s1_flags_next.full = !s1_flags_next.oor &&
                             (sensor_raw > RAW_W'(CAL_RAW[CAL_POINTS-1]));
        s1_flags_next.zero = sensor_raw == '0;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_thermo_reg <= s1_thermo_next;
            s1_x_reg      <= sensor_raw[X_W-1:0];
            s1_flags_reg  <= s1_flags_next;
        end
    end

    // ---------------- Stage 2: segment select, offset ----------------
    logic [SEG_W-1:0] s2_seg_next, s2_seg_reg;
    logic [X_W-1:0]   s2_diff;
    logic [DX_W-1:0]  s2_dx_reg;
    flags_t           s2_flags_reg;

    always_comb
    begin
        // Top set bit of the thermometer is the segment index
        s2_seg_next = '0;
        for (int k = 0; k < NUM_SEG; k++)
        begin
            if (s1_thermo_reg[k])
            begin
                s2_seg_next = SEG_W'(k);
            end
        end
        s2_diff = s1_x_reg - CAL_RAW[s2_seg_next];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_seg_reg   <= s2_seg_next;
            s2_dx_reg    <= s2_diff[DX_W-1:0];
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // ---------------- Stage 3: offset times level rise ----------------
    logic [SEG_W-1:0] s3_seg_reg;
    logic [NUM_W-1:0] s3_num_next, s3_num_reg;
    flags_t           s3_flags_reg;

    assign s3_num_next = NUM_W'(s2_dx_reg) * NUM_W'(dlvl_tab[s2_seg_reg]);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_seg_reg   <= s2_seg_reg;
            s3_num_reg   <= s3_num_next;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // ---------------- Stage 4: divide by segment width ----------------
    logic [SEG_W-1:0]  s4_seg_reg;
    logic [PROD_W-1:0] s4_prod;
    logic [Q_W-1:0]    s4_q_reg;
    flags_t            s4_flags_reg;

    assign s4_prod = PROD_W'(s3_num_reg) * PROD_W'(recip_tab[s3_seg_reg]);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_seg_reg   <= s3_seg_reg;
            s4_q_reg     <= s4_prod[RECIP_SHIFT +: Q_W];
            s4_flags_reg <= s3_flags_reg;
        end
    end

    // ---------------- Stage 5: base level, special cases ----------------
    logic [LVL_W-1:0] level_next, level_reg;
    logic             oor_reg;

    always_comb
    begin
        if (s4_flags_reg.oor || s4_flags_reg.zero)
        begin
            level_next = '0;
        end
        else if (s4_flags_reg.full)
        begin
            level_next = LVL_W'(FULL_LEVEL);
        end
        else
        begin
            level_next = CAL_LVL[s4_seg_reg] + LVL_W'(s4_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            level_reg <= level_next;
            oor_reg   <= s4_flags_reg.oor;
        end
    end

    assign out_valid    = v5_reg;
    assign fuel_level   = level_reg;
    assign out_of_range = oor_reg;

endmodule
